// ===== design/mcbd_pkg.sv =====
// Package for the minimum-cofactor block: value widths, shared types and constants.
// It depends on nothing. The interfaces and the top level import it.
package mcbd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int TRIAL_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [TRIAL_BITS-1:0] t_trial;
    typedef logic [TRIAL_BITS:0]   t_rem;
    typedef logic [CNT_BITS-1:0]   t_cnt;

endpackage

// ===== design/mcbd_if.sv =====
// Valid/ready channel interfaces for the request and result transactions.
// These depend on mcbd_pkg for the payload types.
interface mcbd_in_if import mcbd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value total;
    t_value limit;

    modport source (output valid, output total, output limit, input ready);
    modport sink (input valid, input total, input limit, output ready);
endinterface

interface mcbd_out_if import mcbd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value cofactor;

    modport source (output valid, output cofactor, input ready);
    modport sink (input valid, input cofactor, output ready);
endinterface

// ===== design/min_cofactor_of_bounded_divisor.sv =====
// Top level of the minimum-cofactor search: trial division with one shared divider.
// It depends on mcbd_pkg and on the channel interfaces in mcbd_if.sv.
//
// For each request transaction (total n, limit k) the block returns n divided by the
// largest divisor of n that does not exceed k. If n <= k or k == 1 the answer is
// known at once and the block goes straight to its finish state. Otherwise every
// trial divisor i from 1 up to floor(sqrt(n)) + 1 takes one pass of a restoring
// divider that yields VALUE_BITS quotient bits, then an evaluation step; the search
// ends at the first i whose quotient is below i. The finish state holds until the
// result register is free. The block takes a new request only when it is idle; the
// result register lets a finished result wait while the next request is accepted.
module min_cofactor_of_bounded_divisor
    import mcbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcbd_in_if.sink          i_req,
    mcbd_out_if.source       o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;
    t_value     r_total;
    t_value     r_limit;
    t_value     r_best;
    t_value     r_quo;
    t_rem       r_rem;
    t_trial     r_trial;
    t_cnt       r_cnt;
    logic       r_out_valid;
    t_value     r_out_cofactor;

    t_rem       n_rem_shift;
    t_rem       n_rem;
    logic       n_qbit;
    t_value     n_trial_ext;
    t_value     n_best_a;
    t_value     n_best_b;
    logic       n_out_free;

    assign i_req.ready    = (r_state == ST_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.cofactor = r_out_cofactor;
    assign n_out_free     = !r_out_valid || o_res.ready;

    always_comb begin
        n_rem_shift = {r_rem[TRIAL_BITS-1:0], r_quo[VALUE_BITS-1]};
        n_qbit      = (n_rem_shift >= {1'b0, r_trial});
        n_rem       = n_qbit ? (n_rem_shift - {1'b0, r_trial}) : n_rem_shift;
        n_trial_ext = t_value'(r_trial);
        n_best_a    = r_best;
        if (n_trial_ext <= r_limit && r_quo < n_best_a) begin
            n_best_a = r_quo;
        end
        n_best_b = n_best_a;
        if (r_quo <= r_limit && n_trial_ext < n_best_b) begin
            n_best_b = n_trial_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_limit     <= '0;
            r_best      <= '0;
            r_trial     <= t_trial'(1);
        end else begin
            if (r_out_valid && o_res.ready && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_total <= i_req.total;
                        r_limit <= i_req.limit;
                        r_trial <= t_trial'(1);
                        r_rem   <= '0;
                        r_quo   <= i_req.total;
                        r_cnt   <= t_cnt'(VALUE_BITS - 1);
                        if (i_req.total <= i_req.limit) begin
                            r_best  <= t_value'(1);
                            r_state <= ST_FIN;
                        end else if (i_req.limit == t_value'(1)) begin
                            r_best  <= i_req.total;
                            r_state <= ST_FIN;
                        end else begin
                            r_best  <= i_req.total;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[VALUE_BITS-2:0], n_qbit};
                    r_cnt <= r_cnt - t_cnt'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (r_quo < n_trial_ext) begin
                        r_state <= ST_FIN;
                    end else begin
                        if (r_rem == '0) begin
                            r_best <= n_best_b;
                        end
                        r_trial <= r_trial + t_trial'(1);
                        r_rem   <= '0;
                        r_quo   <= r_total;
                        r_cnt   <= t_cnt'(VALUE_BITS - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_FIN: begin
                    if (n_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_cofactor <= r_best;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
